// ----- rtl/core/cdq_pkg.sv -----
// Shared types and constants for the circular deque core.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package cdq_pkg;

  // Fixed field widths of the request, response and configuration beats.
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int CAP_W    = 5;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PEEK      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;  // latch the request beat
    logic update;     // apply the operation to pointers, count and storage
    logic capture;    // load the response register from the read data
    logic cfg_write;  // write the capacity register and empty the deque
  } cdq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdq_in_if.sv -----
// Request channel of the circular deque: valid, ready, opcode and value.
// Depends on cdq_pkg for the field widths.
`default_nettype none

interface cdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cdq_pkg::OPCODE_W-1:0]          opcode;
  logic signed [cdq_pkg::VALUE_W-1:0]    item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cdq_out_if.sv -----
// Response channel of the circular deque: valid, ready and the result fields.
// Depends on cdq_pkg for the field widths.
`default_nettype none

interface cdq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic signed [cdq_pkg::VALUE_W-1:0] front_value;
  logic signed [cdq_pkg::VALUE_W-1:0] rear_value;
  logic                               is_empty;
  logic                               is_full;

  modport source (output valid, output accepted, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cdq_cfg_if.sv -----
// Configuration write channel of the circular deque: valid, ready and capacity.
// Depends on cdq_pkg for the field width.
`default_nettype none

interface cdq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cdq_pkg::CAP_W-1:0]  active_capacity;

  modport source (output valid, output active_capacity, input ready);
  modport sink   (input valid, input active_capacity, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cdq_ram.sv -----
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                     rdata_a,
  output logic      [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/cdq_ctrl.sv -----
// Controller of the circular deque: sequences each request through update,
// read and response capture, and owns the response valid flag.
// Depends on cdq_pkg for the command struct.
`default_nettype none

module cdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  output cdq_pkg::cdq_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_LOAD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // The response register can take a new beat when empty or being drained.
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.take_item = in_valid && (state == S_IDLE);
    cmd.update    = (state == S_UPDATE);
    cmd.capture   = (state == S_LOAD) && out_free;
    cmd.cfg_write = cfg_valid;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cdq_datapath.sv -----
// Datapath of the circular deque: capacity register, head and tail pointers,
// entry count, ring storage and the response register.
// Depends on cdq_pkg and cdq_ram.
`default_nettype none

module cdq_datapath #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cdq_pkg::cdq_cmd_t                  cmd,
  input  wire logic [cdq_pkg::OPCODE_W-1:0]       opcode,
  input  wire logic [cdq_pkg::VALUE_W-1:0]        item_value,
  input  wire logic [cdq_pkg::CAP_W-1:0]          active_capacity,
  output logic                                    accepted,
  output logic [cdq_pkg::VALUE_W-1:0]             front_value,
  output logic [cdq_pkg::VALUE_W-1:0]             rear_value,
  output logic                                    is_empty,
  output logic                                    is_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [cdq_pkg::VALUE_W-1:0] EMPTY_WORD =
    cdq_pkg::VALUE_W'({DATA_WIDTH{1'b1}});

  logic [cdq_pkg::CAP_W-1:0]    cap;
  logic [CNT_W-1:0]             eff_cap;
  logic [PTR_W-1:0]             head;
  logic [PTR_W-1:0]             head_next;
  logic [PTR_W-1:0]             tail;
  logic [PTR_W-1:0]             tail_next;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic [cdq_pkg::OPCODE_W-1:0] op;
  logic [cdq_pkg::VALUE_W-1:0]  value;
  logic                         ok;
  logic                         ok_next;
  logic                         wr_en;
  logic [PTR_W-1:0]             wr_addr;
  logic [DATA_WIDTH-1:0]        rd_front;
  logic [DATA_WIDTH-1:0]        rd_rear;
  logic                         has_room;
  logic                         has_entry;
  logic                         empty_now;

  // Step a slot forward, wrapping at the effective capacity.
  function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] p1;
    p1 = CNT_W'(p) + CNT_W'(1);
    return (p1 >= c) ? '0 : PTR_W'(p1);
  endfunction

  // Step a slot backward, wrapping at the effective capacity.
  function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] pe;
    pe = CNT_W'(p);
    return (pe == '0 || pe >= c) ? PTR_W'(c - CNT_W'(1)) : PTR_W'(pe - CNT_W'(1));
  endfunction

  // Effective capacity: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign has_room  = (count < eff_cap);
  assign has_entry = (count != '0);

  // Operation decode: new pointers, count and the storage write.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok_next    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    unique case (op)
      cdq_pkg::OP_INS_FRONT: begin
        if (has_room) begin
          wr_en      = 1'b1;
          wr_addr    = head;
          head_next  = slot_dec(head, eff_cap);
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::OP_INS_BACK: begin
        if (has_room) begin
          wr_en      = 1'b1;
          wr_addr    = slot_inc(tail, eff_cap);
          tail_next  = slot_inc(tail, eff_cap);
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::OP_DEL_FRONT: begin
        if (has_entry) begin
          head_next  = slot_inc(head, eff_cap);
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::OP_DEL_BACK: begin
        if (has_entry) begin
          tail_next  = slot_dec(tail, eff_cap);
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::OP_PEEK: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Capacity, pointers and count. A capacity write empties the deque.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= cdq_pkg::CAP_RESET;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.cfg_write) begin
      cap   <= active_capacity;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.update) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Request beat and operation outcome.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op    <= opcode;
      value <= item_value;
    end
    if (cmd.update) begin
      ok <= ok_next;
    end
  end

  // Ring storage; the reads follow the pointers after the update.
  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.update && wr_en),
    .waddr   (wr_addr),
    .wdata   (DATA_WIDTH'(value)),
    .raddr_a (slot_inc(head, eff_cap)),
    .raddr_b (tail),
    .rdata_a (rd_front),
    .rdata_b (rd_rear)
  );

  assign empty_now = (count == '0);

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      accepted    <= ok;
      front_value <= empty_now ? EMPTY_WORD : cdq_pkg::VALUE_W'(rd_front);
      rear_value  <= empty_now ? EMPTY_WORD : cdq_pkg::VALUE_W'(rd_rear);
      is_empty    <= empty_now;
      is_full     <= (count == eff_cap);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/circular_deque_core.sv -----
// Circular deque core: top level joining the controller and the datapath.
// Depends on cdq_pkg, the channel interfaces, cdq_ctrl, cdq_datapath and cdq_ram.
//
// A double-ended ring buffer of up to DEPTH entries of DATA_WIDTH bits, of
// which the capacity register enables 1 to DEPTH slots (0 acts as 1). Every
// request beat (insert front, insert back, delete front, delete back, peek)
// yields exactly one response beat with the success flag, the first and last
// entries after the operation (all ones when empty) and the empty and full
// flags. Requests are handled one at a time: the accepting edge latches the
// request, then the pointers are updated and the storage written, the ring
// memory performs its registered read at the new front and rear slots, and
// the response register is loaded once it is free to take the beat. No new
// request is taken before the previous one has reached the response register.
// The response register lets the next request be accepted while a response
// is still waiting. A capacity write empties the deque and must only be made
// while the block is idle. No clearing pass follows reset.
`default_nettype none

module circular_deque_core #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  cdq_in_if.sink     req,
  cdq_out_if.source  rsp,
  cdq_cfg_if.sink    cfg
);

  cdq_pkg::cdq_cmd_t            cmd;
  logic [cdq_pkg::VALUE_W-1:0]  front_bits;
  logic [cdq_pkg::VALUE_W-1:0]  rear_bits;

  // Sequencer.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cmd       (cmd)
  );

  // Pointers, storage and response register.
  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .opcode          (req.opcode),
    .item_value      (req.item_value),
    .active_capacity (cfg.active_capacity),
    .accepted        (rsp.accepted),
    .front_value     (front_bits),
    .rear_value      (rear_bits),
    .is_empty        (rsp.is_empty),
    .is_full         (rsp.is_full)
  );

  assign rsp.front_value = $signed(front_bits);
  assign rsp.rear_value  = $signed(rear_bits);

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_core. It runs directed and random deque traffic
// through an internal predictor, with bursty requests and a stalling response side.
// Depends on cdq_pkg, the request, response and configuration interfaces, and the core RTL.

module tb_top;
  import cdq_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RESP_LATENCY = 4;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 760;
  localparam int MAX_REPORTS  = 40;
  localparam int RING_SLOTS   = DEPTH_DEFAULT;

  // Opcodes above the peek code are not defined and must leave the deque alone.
  localparam logic [OPCODE_W-1:0] OP_BAD_FIRST = OP_PEEK + 1'b1;
  localparam logic [OPCODE_W-1:0] OP_BAD_LAST  = '1;

  localparam logic [VALUE_W-1:0] EMPTY_MARK  = '1;
  localparam logic [VALUE_W-1:0] VAL_MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [CAP_W-1:0] CAP_ZERO        = '0;
  localparam logic [CAP_W-1:0] CAP_ONE         = CAP_W'(1);
  localparam logic [CAP_W-1:0] CAP_ABOVE_DEPTH = CAP_W'(DEPTH_DEFAULT + 1);
  localparam logic [CAP_W-1:0] CAP_MAX         = '1;

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] rear_value;
    logic               is_empty;
    logic               is_full;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst;

  cdq_in_if  req_ch ();
  cdq_out_if rsp_ch ();
  cdq_cfg_if cfg_ch ();

  circular_deque_core #(
    .DEPTH      (DEPTH_DEFAULT),
    .DATA_WIDTH (DATA_WIDTH_DEFAULT)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Predictor state: a private copy of the ring, its pointers and the capacity.
  logic [VALUE_W-1:0] ring_copy [RING_SLOTS];
  int                 head_pos;
  int                 tail_pos;
  int                 live_count;
  logic [CAP_W-1:0]   cap_setting;

  deque_result_t expected_results [$];
  int            error_count;
  int            burst_left;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Effective capacity: zero acts as one, anything above the ring size as the ring size.
  function automatic int usable_slots();
    if (cap_setting == CAP_ZERO) return 1;
    if (cap_setting > RING_SLOTS) return RING_SLOTS;
    return int'(cap_setting);
  endfunction

  function automatic int slot_up(input int p, input int n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  function automatic int slot_down(input int p, input int n);
    return (p == 0 || p >= n) ? n - 1 : p - 1;
  endfunction

  function automatic void clear_deque_copy();
    head_pos   = 0;
    tail_pos   = 0;
    live_count = 0;
  endfunction

  // Applies one operation to the private copy and returns the response it should produce.
  function automatic deque_result_t apply_deque_op(input logic [OPCODE_W-1:0] op,
                                                   input logic [VALUE_W-1:0] val);
    int            n;
    deque_result_t r;
    n = usable_slots();
    r = '0;
    case (op)
      OP_INS_FRONT: begin
        if (live_count < n) begin
          ring_copy[head_pos % RING_SLOTS] = val;
          head_pos = slot_down(head_pos, n);
          live_count++;
          r.accepted = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (live_count < n) begin
          tail_pos = slot_up(tail_pos, n);
          ring_copy[tail_pos % RING_SLOTS] = val;
          live_count++;
          r.accepted = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (live_count != 0) begin
          head_pos = slot_up(head_pos, n);
          live_count--;
          r.accepted = 1'b1;
        end
      end
      OP_DEL_BACK: begin
        if (live_count != 0) begin
          tail_pos = slot_down(tail_pos, n);
          live_count--;
          r.accepted = 1'b1;
        end
      end
      OP_PEEK: begin
        r.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    if (live_count == 0) begin
      r.front_value = EMPTY_MARK;
      r.rear_value  = EMPTY_MARK;
    end else begin
      r.front_value = ring_copy[slot_up(head_pos, n) % RING_SLOTS];
      r.rear_value  = ring_copy[tail_pos % RING_SLOTS];
    end
    r.is_empty = (live_count == 0);
    r.is_full  = (live_count == n);
    return r;
  endfunction

  // Values lean toward the signed extremes and the all-ones pattern that marks an empty deque.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX_POS;
      1: return VAL_MIN_NEG;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input string detail);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s: %s", $time, what, detail);
  endtask

  // Compares one response beat against the oldest expectation.
  task automatic check_response();
    deque_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("response", "beat arrived with no request outstanding");
      return;
    end
    want = expected_results.pop_front();
    if (rsp_ch.accepted !== want.accepted)
      report_mismatch("accepted", $sformatf("got %b, expected %b", rsp_ch.accepted,
                                            want.accepted));
    if (rsp_ch.front_value !== want.front_value)
      report_mismatch("front_value", $sformatf("got %h, expected %h", rsp_ch.front_value,
                                               want.front_value));
    if (rsp_ch.rear_value !== want.rear_value)
      report_mismatch("rear_value", $sformatf("got %h, expected %h", rsp_ch.rear_value,
                                              want.rear_value));
    if (rsp_ch.is_empty !== want.is_empty)
      report_mismatch("is_empty", $sformatf("got %b, expected %b", rsp_ch.is_empty,
                                            want.is_empty));
    if (rsp_ch.is_full !== want.is_full)
      report_mismatch("is_full", $sformatf("got %b, expected %b", rsp_ch.is_full,
                                           want.is_full));
  endtask

  // Sends one request beat. Bursts of random length are separated by random gaps, and valid
  // stays high between beats of a burst.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(apply_deque_op(op, val));
  endtask

  // Holds requests back until every response is in and the pipeline has had time to settle.
  task automatic settle_idle();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (RESP_LATENCY) @(posedge clk);
  endtask

  // Capacity writes happen only with the block idle; each one also empties the deque.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle_idle();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.active_capacity <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_setting = cap;
    clear_deque_copy();
  endtask

  // Operations on the empty deque right after reset, including every undefined opcode.
  task automatic test_empty_deque();
    send_item(OP_PEEK, random_value());
    send_item(OP_DEL_FRONT, random_value());
    send_item(OP_DEL_BACK, random_value());
    for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++)
      send_item(OPCODE_W'(op), random_value());
  endtask

  // Extreme values at both ends, undefined opcodes with entries present, and a delete too many.
  task automatic test_value_extremes();
    send_item(OP_INS_FRONT, VAL_MAX_POS);
    send_item(OP_INS_BACK, VAL_MIN_NEG);
    send_item(OP_INS_FRONT, '1);
    send_item(OP_INS_BACK, '0);
    send_item(OP_PEEK, '1);
    send_item(OP_BAD_LAST, VAL_MAX_POS);
    send_item(OP_BAD_FIRST, VAL_MIN_NEG);
    send_item(OP_DEL_FRONT, '0);
    send_item(OP_DEL_BACK, '0);
    send_item(OP_DEL_FRONT, '0);
    send_item(OP_DEL_BACK, '0);
    send_item(OP_DEL_BACK, '0);
  endtask

  // Capacity of one, zero acting as one, and values above the ring size; it ends with a full
  // deque, which the next capacity write must clear.
  task automatic test_capacity_limits();
    write_capacity(CAP_ONE);
    send_item(OP_INS_BACK, random_value());
    send_item(OP_INS_FRONT, random_value());
    send_item(OP_PEEK, random_value());
    send_item(OP_DEL_FRONT, random_value());
    send_item(OP_INS_FRONT, random_value());
    send_item(OP_DEL_BACK, random_value());
    send_item(OP_DEL_BACK, random_value());

    write_capacity(CAP_ZERO);
    send_item(OP_INS_FRONT, random_value());
    send_item(OP_INS_BACK, random_value());
    send_item(OP_DEL_BACK, random_value());

    // One insert more than the ring holds, wrapping the head pointer past slot zero.
    write_capacity(CAP_MAX);
    for (int i = 0; i <= RING_SLOTS; i++)
      send_item(i[0] ? OP_INS_BACK : OP_INS_FRONT, random_value());
    for (int i = 0; i <= RING_SLOTS; i++)
      send_item(i[1] ? OP_DEL_BACK : OP_DEL_FRONT, random_value());

    write_capacity(CAP_ABOVE_DEPTH);
    for (int i = 0; i <= RING_SLOTS; i++)
      send_item(i[1] ? OP_INS_BACK : OP_INS_FRONT, random_value());
    send_item(OP_PEEK, random_value());
  endtask

  // Segments of random traffic, each under its own capacity. The mix flips its insert share
  // halfway through, from filling to draining or back, so that both the full and the empty states come up often.
  task automatic test_random_traffic();
    int                sent;
    int                seg_len;
    int                insert_pct;
    int                pick;
    logic [CAP_W-1:0]  cap;
    logic [OPCODE_W-1:0] op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: cap = CAP_W'($urandom_range(1, 4));
        1: cap = CAP_RESET;
        default: cap = CAP_W'($urandom());
      endcase
      write_capacity(cap);
      seg_len = $urandom_range(40, 110);
      insert_pct = 25 * $urandom_range(1, 3);
      for (int i = 0; i < seg_len; i++) begin
        // Halfway through, let every response drain before going on.
        if (i == seg_len / 2) begin
          settle_idle();
          insert_pct = 100 - insert_pct;
        end
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
          op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
        else if (pick < 96)
          op = $urandom_range(0, 1) ? OP_DEL_BACK : OP_DEL_FRONT;
        else if (pick < 98)
          op = OP_PEEK;
        else
          op = OPCODE_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        send_item(op, random_value());
      end
      sent += seg_len;
    end
  endtask

  // Response side: checks every beat and stalls on a pattern that changes now and then.
  initial begin : response_sink
    sink_mode_t mode;
    int         mode_left;
    int         cycle_ctr;
    rsp_ch.ready = 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    cycle_ctr = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_response();
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      cycle_ctr++;
      case (mode)
        SINK_OPEN:   rsp_ch.ready <= 1'b1;
        SINK_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default:     rsp_ch.ready <= (cycle_ctr % 7) < 4;
      endcase
    end
  end

  // Main sequence.
  initial begin
    rst                    = 1'b1;
    req_ch.valid           = 1'b0;
    req_ch.opcode          = OP_PEEK;
    req_ch.item_value      = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.active_capacity = CAP_RESET;
    error_count            = 0;
    burst_left             = 0;
    cap_setting            = CAP_RESET;
    clear_deque_copy();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_deque();
    test_value_extremes();
    test_capacity_limits();
    test_random_traffic();

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
